// ----- design/dkts_pkg.sv -----
// ----------------------------------------------------------------------------
// dkts_pkg
// Shared widths and control types for the descending key/tag sorter.
// ----------------------------------------------------------------------------
package dkts_pkg;

  // fixed field widths of the channels
  localparam int KEY_W     = 32;
  localparam int TAG_PORT_W = 16;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;   // a new pair enters the chain
    logic unload;   // every cell takes its successor's entry
  } dkts_ctrl_t;

endpackage

// ----- design/dkts_in_if.sv -----
// ----------------------------------------------------------------------------
// dkts_in_if
// Input channel: one (key, tag) pair per beat, with the last-of-set mark.
// ----------------------------------------------------------------------------
interface dkts_in_if
  import dkts_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [KEY_W-1:0]      sort_key;
  logic [TAG_PORT_W-1:0] payload_tag;
  logic                  final_item;

  modport source (output valid, output sort_key, output payload_tag,
                  output final_item, input ready);
  modport sink   (input valid, input sort_key, input payload_tag,
                  input final_item, output ready);
endinterface

// ----- design/dkts_out_if.sv -----
// ----------------------------------------------------------------------------
// dkts_out_if
// Result channel: one sorted (key, tag) pair per beat with set status bits.
// ----------------------------------------------------------------------------
interface dkts_out_if
  import dkts_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [KEY_W-1:0]      sorted_key;
  logic [TAG_PORT_W-1:0] sorted_tag;
  logic                  end_of_set;
  logic                  overflowed;

  modport source (output valid, output sorted_key, output sorted_tag,
                  output end_of_set, output overflowed, input ready);
  modport sink   (input valid, input sorted_key, input sorted_tag,
                  input end_of_set, input overflowed, output ready);
endinterface

// ----- design/dkts_cell.sv -----
// ----------------------------------------------------------------------------
// dkts_cell
// One slot of the insertion chain: holds an entry, compares it against the
// incoming key, and shifts down on insert or up on unload.
// ----------------------------------------------------------------------------
module dkts_cell
  import dkts_pkg::*;
#(
  parameter int TAG_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dkts_ctrl_t       ctrl,
  input  logic [KEY_W-1:0] new_key,
  input  logic [TAG_W-1:0] new_tag,
  // predecessor (toward the head)
  input  logic             prev_take,
  input  logic             prev_valid,
  input  logic [KEY_W-1:0] prev_key,
  input  logic [TAG_W-1:0] prev_tag,
  // successor (toward the tail)
  input  logic             next_valid,
  input  logic [KEY_W-1:0] next_key,
  input  logic [TAG_W-1:0] next_tag,
  // own entry
  output logic             take,
  output logic             valid,
  output logic [KEY_W-1:0] key,
  output logic [TAG_W-1:0] tag
);

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;

  // strict compare keeps equal keys in load order
  assign take = ctrl.insert && (!valid_r || (new_key > key_r));

  // next entry
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    tag_nxt   = tag_r;
    if (ctrl.unload) begin
      valid_nxt = next_valid;
      key_nxt   = next_key;
      tag_nxt   = next_tag;
    end else if (take) begin
      if (prev_take) begin
        valid_nxt = prev_valid;
        key_nxt   = prev_key;
        tag_nxt   = prev_tag;
      end else begin
        valid_nxt = 1'b1;
        key_nxt   = new_key;
        tag_nxt   = new_tag;
      end
    end
  end

  // valid bit under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign tag   = tag_r;

endmodule

// ----- design/descending_key_tag_sorter_unit.sv -----
// ----------------------------------------------------------------------------
// descending_key_tag_sorter_unit
// Insertion-chain sorter: loads (key, tag) pairs and, on the last pair of a
// set, streams them out largest key first, equal keys in load order.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents                                  | handshake
//  in_ch   | in  | sort_key, payload_tag, final_item              | valid/ready
//  out_ch  | out | sorted_key, sorted_tag, end_of_set, overflowed | valid/ready
//
//  loading takes one pair per cycle outside a drain; each cell compares
//  combinationally and shifts at the clock edge, so a pair lands in its slot at the edge that accepts it.
//  a set of n stored pairs drains from the head cell, one pair per out_ch beat; in_ch is
//  not ready from the final beat until the end_of_set beat leaves.
//  out_ch stalls simply freeze the chain.
//  synchronous active-low reset empties the chain and clears the drop flag.
// ----------------------------------------------------------------------------
module descending_key_tag_sorter_unit
  import dkts_pkg::*;
#(
  parameter int SLOTS    = 32,
  parameter int TAG_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dkts_in_if.sink   in_ch,
  dkts_out_if.source out_ch
);

  localparam int TAG_W = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;

  logic             emit_r, emit_nxt;
  logic             drop_r, drop_nxt;
  logic             in_fire, out_fire, out_last, full;
  dkts_ctrl_t       ctrl;
  logic [TAG_W-1:0] new_tag;

  logic             take_w  [SLOTS];
  logic             valid_w [SLOTS];
  logic [KEY_W-1:0] key_w   [SLOTS];
  logic [TAG_W-1:0] tag_w   [SLOTS];

  // handshake and chain commands
  assign in_ch.ready = !emit_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign full        = valid_w[SLOTS-1];
  assign out_last    = !valid_w[1];
  assign new_tag     = in_ch.payload_tag[TAG_W-1:0];
  assign ctrl.insert = in_fire && !full;
  assign ctrl.unload = out_fire;

  // the chain of cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic             p_take, p_valid, n_valid;
    logic [KEY_W-1:0] p_key, n_key;
    logic [TAG_W-1:0] p_tag, n_tag;

    if (i == 0) begin : g_head
      assign p_take  = 1'b0;
      assign p_valid = 1'b0;
      assign p_key   = '0;
      assign p_tag   = '0;
    end else begin : g_body
      assign p_take  = take_w[i-1];
      assign p_valid = valid_w[i-1];
      assign p_key   = key_w[i-1];
      assign p_tag   = tag_w[i-1];
    end

    if (i == SLOTS-1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_key   = '0;
      assign n_tag   = '0;
    end else begin : g_link
      assign n_valid = valid_w[i+1];
      assign n_key   = key_w[i+1];
      assign n_tag   = tag_w[i+1];
    end

    dkts_cell #(.TAG_W(TAG_W)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_key    (in_ch.sort_key),
      .new_tag    (new_tag),
      .prev_take  (p_take),
      .prev_valid (p_valid),
      .prev_key   (p_key),
      .prev_tag   (p_tag),
      .next_valid (n_valid),
      .next_key   (n_key),
      .next_tag   (n_tag),
      .take       (take_w[i]),
      .valid      (valid_w[i]),
      .key        (key_w[i]),
      .tag        (tag_w[i])
    );
  end

  // emit mode and drop flag
  always_comb begin
    emit_nxt = emit_r;
    drop_nxt = drop_r;
    if (in_fire) begin
      if (full) drop_nxt = 1'b1;
      if (in_ch.final_item) emit_nxt = 1'b1;
    end
    if (out_fire && out_last) begin
      emit_nxt = 1'b0;
      drop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
      drop_r <= 1'b0;
    end else begin
      emit_r <= emit_nxt;
      drop_r <= drop_nxt;
    end
  end

  // results come straight from the head cell
  assign out_ch.valid      = emit_r;
  assign out_ch.sorted_key = key_w[0];
  assign out_ch.sorted_tag = TAG_PORT_W'(tag_w[0]);
  assign out_ch.end_of_set = out_last;
  assign out_ch.overflowed = drop_r;

`ifndef SYNTHESIS
  // a result beat always has a live head entry
  a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> valid_w[0])
    else $error("result offered from an empty head cell");

  // the final pair always starts a drain
  a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.final_item) |=> (out_ch.valid && valid_w[0]))
    else $error("final beat did not start the drain");

  // the end-of-set beat leaves the chain empty and ready
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last) |=> (!valid_w[0] && in_ch.ready && !drop_r))
    else $error("chain not empty after end of set");
`endif

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the descending key/tag sorter. A driver pushes
// (key, tag) sets through the input channel, a predictor keeps its own sorted
// copy of the store and queues the beats each final pair should release, and
// a monitor checks every result beat against the oldest queued one. Both
// sides throttle at random, and once the receiver holds off for a long
// stretch so that the sorter has to stall its input.
// ----------------------------------------------------------------------------
module tb
  import dkts_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 32;
  localparam int TAG_BITS    = 16;
  localparam int HOLD_AT     = 25;
  localparam int HOLD_CYCLES = 300;
  localparam logic [TAG_PORT_W-1:0] TAG_MASK = TAG_PORT_W'((64'd1 << TAG_BITS) - 1);

  typedef struct {
    logic [KEY_W-1:0]      key;
    logic [TAG_PORT_W-1:0] tag;
    logic                  last;
  } pair_beat_t;

  typedef struct {
    logic [KEY_W-1:0]      key;
    logic [TAG_PORT_W-1:0] tag;
    logic                  eos;
    logic                  ovf;
  } sorted_beat_t;

  logic clk;
  logic rst_n;

  dkts_in_if  in_ch ();
  dkts_out_if out_ch ();

  descending_key_tag_sorter_unit #(
    .SLOTS   (SLOTS),
    .TAG_BITS(TAG_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  pair_beat_t   pending_pairs[$];
  sorted_beat_t sorted_due[$];

  // predicted store contents, kept in descending key order
  logic [KEY_W-1:0]      held_key[SLOTS];
  logic [TAG_PORT_W-1:0] held_tag[SLOTS];
  int                    held_count;
  logic                  drop_seen;

  int         plan_total;
  int         sent_count;
  int         fails;
  int         hold_left;
  bit         hold_done;
  pair_beat_t next_pair;
  pair_beat_t taken_pair;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // insert one accepted pair, release the sorted set on a final pair
  task automatic sort_pair_in(input pair_beat_t p);
    int           pos;
    int           k;
    sorted_beat_t sb;
    if (held_count >= SLOTS) begin
      drop_seen = 1'b1;
    end else begin
      pos = 0;
      while (pos < held_count && held_key[pos] >= p.key) pos++;
      for (k = held_count; k > pos; k--) begin
        held_key[k] = held_key[k-1];
        held_tag[k] = held_tag[k-1];
      end
      held_key[pos] = p.key;
      held_tag[pos] = p.tag & TAG_MASK;
      held_count++;
    end
    if (p.last) begin
      for (k = 0; k < held_count; k++) begin
        sb.key = held_key[k];
        sb.tag = held_tag[k];
        sb.eos = (k == held_count - 1);
        sb.ovf = drop_seen;
        sorted_due = {sorted_due, sb};
      end
      held_count = 0;
      drop_seen  = 1'b0;
    end
  endtask

  // idle percentage for either side, by run phase
  function automatic int idle_pct(input bit sender);
    int phase;
    phase = (plan_total > 0) ? (sent_count * 3) / plan_total : 2;
    if (phase == 0) return sender ? 28 : 68;
    if (phase == 1) return sender ? 68 : 28;
    return 0;
  endfunction

  task automatic queue_pair(input logic [KEY_W-1:0] key, input logic [TAG_PORT_W-1:0] tag,
                            input logic last);
    pair_beat_t p;
    p.key  = key;
    p.tag  = tag;
    p.last = last;
    pending_pairs = {pending_pairs, p};
  endtask

  // key flavors: full range, a few values for ties, or extremes
  function automatic logic [KEY_W-1:0] pick_key(input int flavor);
    case (flavor)
      0: return $urandom;
      1: return KEY_W'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return {1'b1, {(KEY_W-1){1'b0}}};
          default: return {1'b0, {(KEY_W-1){1'b1}}};
        endcase
      end
    endcase
  endfunction

  task automatic queue_set(input int len);
    int flavor;
    int i;
    flavor = $urandom_range(0, 2);
    for (i = 0; i < len; i++)
      queue_pair(pick_key(flavor), TAG_PORT_W'($urandom), i == len - 1);
  endtask

  // driver: offers pending pairs, feeds the predictor on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken_pair.key  = in_ch.sort_key;
        taken_pair.tag  = in_ch.payload_tag;
        taken_pair.last = in_ch.final_item;
        sort_pair_in(taken_pair);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          next_pair = pending_pairs.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.sort_key    <= next_pair.key;
          in_ch.payload_tag <= next_pair.tag;
          in_ch.final_item  <= next_pair.last;
          sent_count        <= sent_count + 1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off during a large set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // monitor: every result beat against the oldest expected one
  always @(posedge clk) begin
    sorted_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sorted_due.size() == 0) begin
        $error("result beat with nothing expected: sorted_key %h sorted_tag %h",
               out_ch.sorted_key, out_ch.sorted_tag);
        fails++;
      end else begin
        want = sorted_due.pop_front();
        if (out_ch.sorted_key !== want.key) begin
          $error("sorted_key expected %h actual %h", want.key, out_ch.sorted_key);
          fails++;
        end
        if (out_ch.sorted_tag !== want.tag) begin
          $error("sorted_tag expected %h actual %h", want.tag, out_ch.sorted_tag);
          fails++;
        end
        if (out_ch.end_of_set !== want.eos) begin
          $error("end_of_set expected %b actual %b", want.eos, out_ch.end_of_set);
          fails++;
        end
        if (out_ch.overflowed !== want.ovf) begin
          $error("overflowed expected %b actual %b", want.ovf, out_ch.overflowed);
          fails++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int guard;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.sort_key    = '0;
    in_ch.payload_tag = '0;
    in_ch.final_item  = 1'b0;
    out_ch.ready      = 1'b0;
    held_count        = 0;
    drop_seen         = 1'b0;
    sent_count        = 0;
    fails             = 0;
    hold_left         = 0;
    hold_done         = 1'b0;
    plan_total        = 0;

    // directed: single-pair sets at both extremes
    queue_pair('0, '0, 1'b1);
    queue_pair('1, '1, 1'b1);
    // equal keys keep load order
    queue_pair(32'd5, 16'd1, 1'b0);
    queue_pair(32'd5, 16'd2, 1'b0);
    queue_pair(32'd5, 16'd3, 1'b1);
    // ascending input, fully reversed on output
    queue_pair(32'd1, 16'd10, 1'b0);
    queue_pair(32'd2, 16'd11, 1'b0);
    queue_pair(32'd3, 16'd12, 1'b0);
    queue_pair(32'd4, 16'd13, 1'b1);
    // extremes mixed, zero keys tied
    queue_pair('0, '1, 1'b0);
    queue_pair('1, '0, 1'b0);
    queue_pair(32'h8000_0000, 16'h8000, 1'b0);
    queue_pair(32'h7fff_ffff, 16'h7fff, 1'b0);
    queue_pair('0, 16'd1, 1'b1);
    // already descending
    queue_pair(32'd9, 16'd0, 1'b0);
    queue_pair(32'd8, 16'd1, 1'b0);
    queue_pair(32'd7, 16'd2, 1'b1);

    // overflow set (hold-off lands here), exactly full, one past full
    queue_set(40);
    queue_set(SLOTS);
    queue_set(SLOTS + 1);

    // random sets, mostly short, some past capacity
    while (pending_pairs.size() < 350) begin
      if ($urandom_range(0, 9) == 0) queue_set($urandom_range(28, 40));
      else                           queue_set($urandom_range(1, 12));
    end
    plan_total = pending_pairs.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() > 0 || in_ch.valid) @(posedge clk);
    guard = 0;
    while (sorted_due.size() > 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
    if (sorted_due.size() != 0) begin
      $error("%0d expected result beats never arrived", sorted_due.size());
      fails++;
    end

    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
